// File: sv/mot_pkg.sv
// Package for the multitouch order tracker: shared widths, types and codes.
// No dependencies; every other file but mot_if imports it.
`default_nettype none
package mot_pkg;
	localparam int unsigned NUM_FIELDS = 5;
	localparam int unsigned FIELD_BITS = 16;
	localparam logic signed [3:0] INDEX_NONE = 4'sb1111;

	// Result of one lane's search over the previous slots.
	typedef struct packed {
		logic        found;
		logic [31:0] gap;
		logic [7:0]  slot;
	} lane_best_t;
endpackage
`default_nettype wire

// File: sv/mot_if.sv
// Valid/ready channel interface for the multitouch order tracker.
// Depends on nothing; payload width is a parameter.
`default_nettype none
interface mot_if #(parameter int unsigned W = 8) (input wire logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/mot_lane.sv
// One lane: for one current touch, finds the nearest free previous slot.
// Depends on mot_pkg. Ties go to the lower slot, which keeps pair order.
`default_nettype none
module mot_lane
	import mot_pkg::*;
#(
	parameter int unsigned MAX_TOUCH = 5,
	parameter int unsigned POS_BITS = 16
) (
	input  wire logic [POS_BITS-1:0]            pos,
	input  wire logic [MAX_TOUCH-1:0][POS_BITS-1:0] slot_pos,
	input  wire logic [MAX_TOUCH-1:0]           slot_free,
	output lane_best_t                          best
);
	logic [POS_BITS-1:0] d;
	always_comb begin
		best = '0;
		d = '0;
		for (int unsigned q = 0; q < MAX_TOUCH; q++) begin
			d = (pos > slot_pos[q]) ? pos - slot_pos[q] : slot_pos[q] - pos;
			if (slot_free[q] && (!best.found || 32'(d) < best.gap)) begin
				best.found = 1'b1;
				best.gap = 32'(d);
				best.slot = 8'(q);
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/mot_merge.sv
// Merging stage: picks the globally smallest lane result, lowest touch on ties.
// Depends on mot_pkg.
`default_nettype none
module mot_merge
	import mot_pkg::*;
#(
	parameter int unsigned MAX_TOUCH = 5
) (
	input  wire lane_best_t [MAX_TOUCH-1:0] lanes,
	input  wire logic [MAX_TOUCH-1:0]  lane_on,
	output logic                       found,
	output logic [$clog2(MAX_TOUCH)-1:0] touch,
	output logic [$clog2(MAX_TOUCH)-1:0] slot
);
	localparam int unsigned SB = $clog2(MAX_TOUCH);

	logic [31:0] bd;
	always_comb begin
		found = 1'b0;
		touch = '0;
		slot = '0;
		bd = '0;
		for (int unsigned c = 0; c < MAX_TOUCH; c++) begin
			if (lane_on[c] && lanes[c].found && (!found || lanes[c].gap < bd)) begin
				found = 1'b1;
				bd = lanes[c].gap;
				touch = SB'(c);
				slot = lanes[c].slot[SB-1:0];
			end
		end
	end
endmodule
`default_nettype wire

// File: sv/multitouch_order_tracker.sv
// Multitouch order tracker: keeps each touch's arrival slot across frames.
// Path: a frame with the count unchanged runs WRITE then SEND, an empty frame goes straight to SEND,
// and a changed count runs MATCH (m greedy matches, up to MAX_TOUCH-1), FILL, WRITE and SEND.
// Input: a new frame is taken only in IDLE, once the last one has gone to the output register;
// a result beat still waiting in the output register holds the next frame in SEND.
// Reset (arst_n low) clears the count, slots and positions and sets the index to none.
`default_nettype none
module multitouch_order_tracker
	import mot_pkg::*;
#(
	parameter int unsigned MAX_TOUCH = 5,
	parameter int unsigned POS_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	mot_if.sink      in_ch,
	mot_if.source    out_ch
);
	localparam int unsigned SB = $clog2(MAX_TOUCH);
	localparam int unsigned CB = $clog2(MAX_TOUCH + 1);

	typedef enum logic [2:0] {IDLE, MATCH, FILL, WRITE, SEND} state_t;
	state_t state_q;

	logic [CB-1:0] n_q, p_q;
	logic [MAX_TOUCH-1:0][POS_BITS-1:0] pos_q, slot_pos_q;
	logic [MAX_TOUCH-1:0][SB-1:0] slot_q;
	logic [MAX_TOUCH-1:0] cur_used_q, prev_used_q;
	logic [CB-1:0] matched_q;
	logic signed [3:0] newest_q;
	logic [FIELD_BITS-1:0] held_q;

	// Output register: the result beat is frozen here until the receiver takes it.
	logic [2:0] out_cnt_q;
	logic signed [3:0] out_idx_q;
	logic [FIELD_BITS-1:0] out_pos_q;
	logic [NUM_FIELDS-1:0][2:0] out_slot_q;

	// Input beat: {count, pos_e .. pos_a} with pos_a in the low bits.
	logic [2:0] cnt_in;
	logic [CB-1:0] n_in;
	assign cnt_in = in_ch.data[NUM_FIELDS*FIELD_BITS +: 3];
	assign n_in = (32'(cnt_in) > MAX_TOUCH) ? CB'(MAX_TOUCH) : CB'(cnt_in);
	assign in_ch.ready = (state_q == IDLE);

	lane_best_t [MAX_TOUCH-1:0] lanes;
	logic [MAX_TOUCH-1:0] lane_on;
	for (genvar c = 0; c < MAX_TOUCH; c++) begin : g_lane
		logic [MAX_TOUCH-1:0] sfree;
		for (genvar q = 0; q < MAX_TOUCH; q++) begin : g_f
			assign sfree[q] = !prev_used_q[q] && (q < p_q);
		end
		assign lane_on[c] = !cur_used_q[c] && (c < n_q);
		mot_lane #(.MAX_TOUCH(MAX_TOUCH), .POS_BITS(POS_BITS)) u_lane (
			.pos(pos_q[c]), .slot_pos(slot_pos_q), .slot_free(sfree), .best(lanes[c]));
	end

	logic m_found;
	logic [SB-1:0] m_touch, m_slot;
	mot_merge #(.MAX_TOUCH(MAX_TOUCH)) u_merge (
		.lanes(lanes), .lane_on(lane_on), .found(m_found), .touch(m_touch), .slot(m_slot));

	// Compaction after losses: slot s drops by the number of unused previous slots below it.
	logic [MAX_TOUCH-1:0][SB-1:0] slot_fix;
	always_comb begin
		for (int unsigned c = 0; c < MAX_TOUCH; c++) begin
			slot_fix[c] = slot_q[c];
			for (int unsigned q = 0; q < MAX_TOUCH; q++) begin
				if (q < p_q && !prev_used_q[q] && 32'(slot_q[c]) > q)
					slot_fix[c] = slot_fix[c] - SB'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			p_q <= '0;
			n_q <= '0;
			pos_q <= '0;
			slot_q <= '0;
			slot_pos_q <= '0;
			newest_q <= INDEX_NONE;
			held_q <= '0;
			cur_used_q <= '0;
			prev_used_q <= '0;
			matched_q <= '0;
			out_cnt_q <= '0;
			out_idx_q <= INDEX_NONE;
			out_pos_q <= '0;
			out_slot_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_ch.valid) begin
						for (int unsigned i = 0; i < MAX_TOUCH; i++)
							pos_q[i] <= (i < NUM_FIELDS) ?
								POS_BITS'(in_ch.data[i*FIELD_BITS +: FIELD_BITS]) : '0;
						n_q <= n_in;
						cur_used_q <= '0;
						prev_used_q <= '0;
						matched_q <= '0;
						if (n_in == '0) begin
							newest_q <= INDEX_NONE;
							state_q <= SEND;
						end else if (n_in != p_q) begin
							state_q <= MATCH;
						end else begin
							state_q <= WRITE;
						end
					end
				end
				MATCH: begin
					if (m_found) begin
						cur_used_q[m_touch] <= 1'b1;
						prev_used_q[m_slot] <= 1'b1;
						slot_q[m_touch] <= m_slot;
						matched_q <= matched_q + CB'(1);
					end else begin
						state_q <= FILL;
					end
				end
				FILL: begin
					if (p_q < n_q) begin
						for (int unsigned c = 0; c < MAX_TOUCH; c++) begin
							if (c < n_q && !cur_used_q[c]) begin
								logic [CB-1:0] k;
								k = matched_q;
								for (int unsigned j = 0; j < c; j++)
									if (j < n_q && !cur_used_q[j]) k = k + CB'(1);
								slot_q[c] <= SB'(k);
							end
						end
					end else begin
						slot_q <= slot_fix;
					end
					state_q <= WRITE;
				end
				WRITE: begin
					for (int unsigned c = 0; c < MAX_TOUCH; c++) begin
						if (c < n_q) begin
							slot_pos_q[slot_q[c]] <= pos_q[c];
							if (p_q != n_q && 32'(slot_q[c]) == 32'(n_q) - 1)
								newest_q <= 4'(c);
						end
					end
					state_q <= SEND;
				end
				SEND: begin
					if (!out_ch.valid) begin
						// An empty frame repeats the held position.
						if (n_q != '0) begin
							held_q <= FIELD_BITS'(slot_pos_q[n_q - CB'(1)]);
							out_pos_q <= FIELD_BITS'(slot_pos_q[n_q - CB'(1)]);
						end else begin
							out_pos_q <= held_q;
						end
						for (int unsigned c = 0; c < MAX_TOUCH; c++)
							if (c < NUM_FIELDS)
								out_slot_q[c] <= (c < n_q) ? 3'(slot_q[c]) : 3'd0;
						out_cnt_q <= 3'(n_q);
						out_idx_q <= newest_q;
						p_q <= n_q;
						out_ch.valid <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
			if (out_ch.valid && out_ch.ready && !(state_q == SEND && !out_ch.valid))
				out_ch.valid <= 1'b0;
		end
	end

	// Output beat: {count, newest_index, newest_pos, slot_e .. slot_a}.
	always_comb begin
		out_ch.data = {out_cnt_q, out_idx_q, out_pos_q, out_slot_q};
	end

	ap_match_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(prev_used_q) <= MAX_TOUCH)
		else $error("more matches than slots");
	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !(state_q == MATCH))
		else $error("ready while matching");
	ap_send_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEND && !out_ch.valid) |=> out_ch.valid)
		else $error("result not presented");
endmodule
`default_nettype wire

// File: test/tb_mot_types.sv
// Beat layouts for the multitouch order tracker testbench.
// Depends on mot_pkg; field order follows the channel payload, first field on top.
`default_nettype none
package tb_mot_types;
	import mot_pkg::*;

	typedef struct packed {
		logic [2:0]                   touch_count;
		logic [4:0][FIELD_BITS-1:0]   pos;
	} frame_t;

	typedef struct packed {
		logic [2:0]                   count_out;
		logic signed [3:0]            newest_index;
		logic [FIELD_BITS-1:0]        newest_pos;
		logic [4:0][2:0]              slot;
	} track_t;
endpackage
`default_nettype wire

// File: test/tb_top.sv
// Testbench for multitouch_order_tracker: directed frames, then random touch sequences.
// Depends on mot_pkg, tb_mot_types, mot_if and the tracker RTL.
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mot_pkg::*;
	import tb_mot_types::*;

	localparam int TOUCHES = 5;
	localparam int RANDOM_FRAMES = 1930;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #10 clk = ~clk;

	mot_if #(.W($bits(frame_t))) in_ch (clk);
	mot_if #(.W($bits(track_t))) out_ch (clk);

	multitouch_order_tracker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Tracker state as the predictor sees it after every accepted frame.
	int unsigned prev_count;
	int unsigned touch_slot[TOUCHES];
	int unsigned slot_pos[TOUCHES];
	int newest_touch;
	int unsigned held_pos;

	track_t pending_tracks[$];
	int errors = 0;
	int cycles = 0;
	bit feeding_done = 1'b0;
	bit quiet_tail = 1'b0;
	bit hold_out = 1'b0;
	int beats_sent = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic int unsigned pos_gap(int unsigned a, int unsigned b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Greedy nearest-neighbour reassignment of arrival slots when the count changes.
	function automatic void reassign_slots(int unsigned n, int unsigned p, frame_t f);
		int unsigned pair_gaps[TOUCHES*TOUCHES];
		int unsigned pid[TOUCHES*TOUCHES];
		bit cur_taken[TOUCHES];
		bit old_taken[TOUCHES];
		int unsigned pairs;
		int unsigned matched;
		int unsigned d;
		int m;
		int unsigned c;
		int unsigned q;
		pairs = n * p;
		matched = 0;
		foreach (cur_taken[i]) begin
			cur_taken[i] = 1'b0;
			old_taken[i] = 1'b0;
		end
		// Stable insertion sort: equal distances keep touch-major pair order.
		for (int unsigned k = 0; k < pairs; k++) begin
			d = pos_gap(f.pos[k / p], slot_pos[k % p]);
			m = k;
			while (m > 0 && d < pair_gaps[m-1]) begin
				pair_gaps[m] = pair_gaps[m-1];
				pid[m] = pid[m-1];
				m--;
			end
			pair_gaps[m] = d;
			pid[m] = k;
		end
		for (int unsigned k = 0; k < pairs; k++) begin
			c = pid[k] / p;
			q = pid[k] % p;
			if (!cur_taken[c] && !old_taken[q]) begin
				cur_taken[c] = 1'b1;
				old_taken[q] = 1'b1;
				touch_slot[c] = q;
				matched++;
			end
		end
		if (p < n) begin
			// New touches queue up behind the matched ones in touch order.
			for (int unsigned i = 0; i < n; i++)
				if (!cur_taken[i])
					touch_slot[i] = matched++;
		end else begin
			// Lost touches: every slot above a vacated one slides down.
			for (int i = p - 1; i >= 0; i--)
				if (!old_taken[i])
					for (int unsigned j = 0; j < n; j++)
						if (touch_slot[j] > i)
							touch_slot[j]--;
		end
		for (int unsigned i = 0; i < n; i++)
			if (touch_slot[i] == n - 1)
				newest_touch = i;
	endfunction

	function automatic track_t track_frame(frame_t f);
		track_t r;
		int unsigned n;
		n = (f.touch_count > TOUCHES) ? TOUCHES : f.touch_count;
		if (n > 0) begin
			if (prev_count != n)
				reassign_slots(n, prev_count, f);
			for (int unsigned i = 0; i < n; i++)
				slot_pos[touch_slot[i] % TOUCHES] = f.pos[i];
			held_pos = slot_pos[n-1];
		end else begin
			newest_touch = -1;
		end
		prev_count = n;
		r.count_out = n[2:0];
		r.newest_pos = held_pos[15:0];
		r.newest_index = newest_touch[3:0];
		for (int i = 0; i < TOUCHES; i++)
			r.slot[i] = (i < n) ? touch_slot[i][2:0] : 3'd0;
		return r;
	endfunction

	// Directed frames. Rows with a typed result are simple enough to read off by hand;
	// the rest go through the predictor.
	typedef struct {
		frame_t f;
		bit     typed;
		track_t want;
	} step_t;

	function automatic frame_t mk(logic [2:0] n, int unsigned a, int unsigned b,
			int unsigned c, int unsigned d, int unsigned e);
		frame_t f;
		f.touch_count = n;
		f.pos = {e[15:0], d[15:0], c[15:0], b[15:0], a[15:0]};
		return f;
	endfunction

	step_t steps[$];

	task automatic build_steps();
		step_t s;
		// Empty frame right after reset: nothing held, index none.
		s.f = mk(0, 'hffff, 'hffff, 'hffff, 'hffff, 'hffff);
		s.typed = 1; s.want = '{3'd0, INDEX_NONE, 16'd0, '0}; steps.push_back(s);
		// First touch at the far end: slot 0, newest is touch 0.
		s.f = mk(1, 'hffff, 0, 0, 0, 0);
		s.typed = 1; s.want = '{3'd1, 4'sd0, 16'hffff, '0}; steps.push_back(s);
		// Same count again: only the position moves.
		s.f = mk(1, 0, 'hffff, 0, 0, 0);
		s.typed = 1; s.want = '{3'd1, 4'sd0, 16'h0000, '0}; steps.push_back(s);
		s.typed = 0;
		s.f = mk(5, 0, 0, 0, 0, 0); steps.push_back(s);          // all ties
		s.f = mk(5, 'hffff, 'h8000, 'h7fff, 1, 'haaaa); steps.push_back(s);
		s.f = mk(6, 'h5555, 'h1234, 'hfedc, 'h0f0f, 'hf0f0); steps.push_back(s); // saturates
		s.f = mk(7, 1, 2, 3, 4, 5); steps.push_back(s);
		s.f = mk(3, 3, 5, 1, 0, 0); steps.push_back(s);          // lose two
		s.f = mk(2, 5, 1, 0, 0, 0); steps.push_back(s);
		s.f = mk(4, 'h4000, 6, 'hc000, 2, 0); steps.push_back(s); // gain two
		s.f = mk(4, 'h4001, 7, 'hc001, 3, 0); steps.push_back(s);
		// Zero touches keeps slots and repeats the held position.
		s.f = mk(0, 'h1111, 'h2222, 'h3333, 'h4444, 'h5555); steps.push_back(s);
		s.f = mk(0, 0, 0, 0, 0, 0); steps.push_back(s);
		s.f = mk(4, 'h4001, 7, 'hc001, 3, 'hbeef); steps.push_back(s);
		s.f = mk(1, 'h8000, 0, 0, 0, 0); steps.push_back(s);
		s.f = mk(5, 'h8000, 'h8000, 'h8000, 'h8000, 'h8000); steps.push_back(s);
		s.f = mk(2, 'hffff, 0, 0, 0, 0); steps.push_back(s);
		s.f = mk(3, 100, 100, 200, 0, 0); steps.push_back(s);
		s.f = mk(1, 150, 0, 0, 0, 0); steps.push_back(s);
		s.f = mk(0, 0, 0, 0, 0, 0); steps.push_back(s);
	endtask

	// Offers one beat and returns once it has been accepted.
	task automatic offer(frame_t f, bit typed, track_t want);
		track_t r;
		int gap;
		if (!quiet_tail && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= f;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		r = track_frame(f);
		pending_tracks.push_back(typed ? want : r);
		beats_sent++;
	endtask

	// Random frames: mostly drifting touches that come and go, some noise.
	task automatic random_frames();
		int unsigned base[TOUCHES];
		int unsigned n;
		int unsigned v;
		frame_t f;
		foreach (base[i]) base[i] = $urandom_range(0, 65535);
		n = 0;
		for (int k = 0; k < RANDOM_FRAMES; k++) begin
			if (k >= RANDOM_FRAMES - 150) quiet_tail = 1'b1;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: ;
				4, 5: if (n < TOUCHES) n++;
				6, 7: if (n > 0) n--;
				8: n = $urandom_range(0, 5);
				default: n = $urandom_range(0, 7);
			endcase
			foreach (base[i]) begin
				case ($urandom_range(0, 7))
					0: base[i] = $urandom_range(0, 65535);
					1: base[i] = base[(i + 1) % TOUCHES];
					2: base[i] = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
					default: begin
						v = base[i] + $urandom_range(0, 2000) - 1000;
						base[i] = v[15:0];
					end
				endcase
			end
			f.touch_count = n[2:0];
			for (int i = 0; i < TOUCHES; i++) f.pos[i] = base[i][15:0];
			// Keep the count saturated or below range so slots stay meaningful.
			if (n > TOUCHES) n = TOUCHES;
			offer(f, 1'b0, '0);
		end
	endtask

	// Sender: reset, directed table, random frames.
	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		prev_count = 0;
		newest_touch = -1;
		held_pos = 0;
		foreach (touch_slot[i]) begin
			touch_slot[i] = 0;
			slot_pos[i] = 0;
		end
		build_steps();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (steps[i]) offer(steps[i].f, steps[i].typed, steps[i].want);
		random_frames();
		in_ch.valid <= 1'b0;
		feeding_done = 1'b1;
		while (pending_tracks.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && pending_tracks.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// One long hold on the output so the tracker backs up and stalls its input.
	initial begin
		wait (beats_sent == 400);
		hold_out = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		hold_out = 1'b0;
	end

	// Receiver: random stall bursts, none in the tail.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_out) begin
				out_ch.ready <= 1'b0;
				@(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 8);
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Output checker: every result beat is compared with the oldest expectation.
	always @(posedge clk) begin
		track_t got;
		track_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (pending_tracks.size() == 0) begin
				$display("unexpected result beat at %0t", $realtime);
				errors++;
			end else begin
				want = pending_tracks.pop_front();
				if (got.count_out !== want.count_out)
					report_mismatch("count_out", got.count_out, want.count_out);
				if (got.newest_pos !== want.newest_pos)
					report_mismatch("newest_pos", got.newest_pos, want.newest_pos);
				if (got.newest_index !== want.newest_index)
					report_mismatch("newest_index", got.newest_index, want.newest_index);
				for (int i = 0; i < TOUCHES; i++)
					if (got.slot[i] !== want.slot[i])
						report_mismatch($sformatf("slot %0d", i), got.slot[i], want.slot[i]);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end
endmodule
`default_nettype wire
